// ===== hw/rtl/bootloader_frame_receiver_defines.svh =====
// Assertion macros for the bootloader frame receiver.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef BOOTLOADER_FRAME_RECEIVER_DEFINES_SVH
`define BOOTLOADER_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTH
// check a property while out of reset
`define BFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on every edge, reset included
`define BFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFR_ASSERT(lbl, prop, msg)
`define BFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/bfr_pkg.sv =====
// Shared types and constants for the bootloader frame receiver.
// No dependencies; used by the parser, the top level and the testbench.
package bfr_pkg;

  localparam logic [7:0]  SYNC_BYTE = 8'hFF;
  localparam logic [7:0]  PAD_BYTE  = 8'hFF;
  localparam logic [7:0]  ANY_VER   = 8'hFF;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODE_START  = 3'd0,
    CFG_CODE_END    = 3'd1,
    CFG_CODE_PG_NUM = 3'd2,
    CFG_CODE_PG_DAT = 3'd3,
    CFG_VER_MAJOR   = 3'd4,
    CFG_VER_MINOR   = 3'd5,
    CFG_VER_CHECK   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_NONE       = 2'd0,
    ST_PAGE_READY = 2'd1,
    ST_DONE       = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] code_start;
    logic [7:0] code_end;
    logic [7:0] code_pg_num;
    logic [7:0] code_pg_dat;
    logic [7:0] ver_major;
    logic [7:0] ver_minor;
    logic       ver_check;
  } cfg_t;

  typedef struct packed {
    status_t status;
    logic    error_pulse;
    logic    signal_on;
    logic    signal_off;
  } flags_t;

  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_wr_t;

endpackage

// ===== hw/rtl/bfr_in_if.sv =====
// Input channel of the frame receiver: opcode, serial byte, read index, page.
// Depends on nothing.
interface bfr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  logic [6:0] read_index;
  logic [7:0] expected_page;

  modport source (output valid, opcode, rx_byte, read_index, expected_page, input ready);
  modport sink   (input valid, opcode, rx_byte, read_index, expected_page, output ready);
endinterface

// ===== hw/rtl/bfr_out_if.sv =====
// Result channel of the frame receiver.
// Depends on nothing.
interface bfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       error_pulse;
  logic       signal_on;
  logic       signal_off;
  logic [7:0] read_data;

  modport source (output valid, status, error_pulse, signal_on, signal_off, read_data,
                  input ready);
  modport sink   (input valid, status, error_pulse, signal_on, signal_off, read_data,
                  output ready);
endinterface

// ===== hw/rtl/bfr_cfg_if.sv =====
// Configuration write channel of the frame receiver: register index and data.
// Depends on nothing.
interface bfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bfr_parser.sv =====
// Frame parser: sync, header, data, CRC-16 check and frame actions.
// Depends on bfr_pkg; drives page buffer writes and the page length.
module bfr_parser #(
  parameter int PAGE_SIZE = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [7:0]                       rx_byte,
  input  logic [7:0]                       expected_page,
  input  bfr_pkg::cfg_t                    cfg,
  output bfr_pkg::flags_t                  flags,
  output bfr_pkg::mem_wr_t                 mem_wr,
  output logic [$clog2(PAGE_SIZE+1)-1:0]   page_len
);
  import bfr_pkg::*;

  localparam int LEN_W = $clog2(PAGE_SIZE + 1);

  typedef enum logic [9:0] {
    PH_SYNC1  = 10'b00_0000_0001,
    PH_SYNC2  = 10'b00_0000_0010,
    PH_FLAGS  = 10'b00_0000_0100,
    PH_ADDR   = 10'b00_0000_1000,
    PH_TYPE   = 10'b00_0001_0000,
    PH_SECLEN = 10'b00_0010_0000,
    PH_LEN    = 10'b00_0100_0000,
    PH_DATA   = 10'b00_1000_0000,
    PH_CRCHI  = 10'b01_0000_0000,
    PH_CRCLO  = 10'b10_0000_0000
  } phase_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  phase_t           phase_r, phase_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       ftype_r, ftype_nxt;
  logic [7:0]       flen_r, flen_nxt;
  logic [7:0]       dcnt_r, dcnt_nxt;
  logic [7:0]       crc_hi_r, crc_hi_nxt;
  logic             armed_r, armed_nxt;
  logic [7:0]       upage_r, upage_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  // shadow copies of buffer positions 0 and 1 for version and page-number frames
  logic [7:0]       byte0_r, byte0_nxt;
  logic [7:0]       byte1_r, byte1_nxt;

  logic [15:0] crc_fed;
  logic [7:0]  dcnt_inc;
  logic        frame_err;
  logic        ver_ok;

  assign crc_fed  = crc_feed(crc_r, rx_byte);
  assign dcnt_inc = dcnt_r + 8'd1;
  assign ver_ok   = !cfg.ver_check ||
                    ((cfg.ver_major == ANY_VER || byte0_r == cfg.ver_major) &&
                     (cfg.ver_minor == ANY_VER || byte1_r == cfg.ver_minor));

  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    ftype_nxt  = ftype_r;
    flen_nxt   = flen_r;
    dcnt_nxt   = dcnt_r;
    crc_hi_nxt = crc_hi_r;
    armed_nxt  = armed_r;
    upage_nxt  = upage_r;
    plen_nxt   = plen_r;
    byte0_nxt  = byte0_r;
    byte1_nxt  = byte1_r;
    frame_err  = 1'b0;
    flags      = '{status: ST_NONE, error_pulse: 1'b0, signal_on: 1'b0, signal_off: 1'b0};
    mem_wr     = '{we: 1'b0, addr: dcnt_r, data: rx_byte};

    unique case (phase_r)
      PH_SYNC1: begin
        if (rx_byte == SYNC_BYTE) begin
          phase_nxt = PH_SYNC2;
        end else begin
          frame_err = 1'b1;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC_BYTE) begin
          crc_nxt   = CRC_INIT;
          flen_nxt  = 8'd0;
          dcnt_nxt  = 8'd0;
          phase_nxt = PH_FLAGS;
        end else begin
          frame_err = 1'b1;
          phase_nxt = PH_SYNC1;
        end
      end
      PH_FLAGS: begin
        crc_nxt   = crc_fed;
        phase_nxt = PH_ADDR;
      end
      PH_ADDR: begin
        crc_nxt   = crc_fed;
        phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        crc_nxt   = crc_fed;
        ftype_nxt = rx_byte;
        phase_nxt = PH_SECLEN;
      end
      PH_SECLEN: begin
        crc_nxt   = crc_fed;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        crc_nxt   = crc_fed;
        flen_nxt  = rx_byte;
        dcnt_nxt  = 8'd0;
        phase_nxt = (rx_byte == 8'd0) ? PH_CRCHI : PH_DATA;
      end
      PH_DATA: begin
        crc_nxt = crc_fed;
        // drop bytes past the end of the page buffer
        if ({1'b0, dcnt_r} < 9'(PAGE_SIZE)) begin
          mem_wr.we = 1'b1;
          if (dcnt_r == 8'd0) begin
            byte0_nxt = rx_byte;
          end
          if (dcnt_r == 8'd1) begin
            byte1_nxt = rx_byte;
          end
        end
        dcnt_nxt = dcnt_inc;
        if (dcnt_inc >= flen_r) begin
          phase_nxt = PH_CRCHI;
        end
      end
      PH_CRCHI: begin
        crc_hi_nxt = rx_byte;
        phase_nxt  = PH_CRCLO;
      end
      PH_CRCLO: begin
        if ({crc_hi_r, rx_byte} != crc_r) begin
          frame_err = 1'b1;
        end else if (ftype_r == cfg.code_start) begin
          flags.signal_off = 1'b1;
          if (ver_ok) begin
            armed_nxt = 1'b1;
          end
        end else if (ftype_r == cfg.code_end) begin
          armed_nxt    = 1'b0;
          flags.status = ST_DONE;
        end else if (armed_r) begin
          if (ftype_r == cfg.code_pg_num) begin
            upage_nxt = byte0_r;
          end else if (ftype_r == cfg.code_pg_dat) begin
            if ({1'b0, flen_r} > 9'(PAGE_SIZE) || upage_r != expected_page) begin
              frame_err = 1'b1;
            end else begin
              // positions past the length read as pad bytes
              if (flen_r == 8'd0) begin
                byte0_nxt = PAD_BYTE;
              end
              if (flen_r <= 8'd1) begin
                byte1_nxt = PAD_BYTE;
              end
              plen_nxt         = LEN_W'(flen_r);
              flags.status     = ST_PAGE_READY;
              flags.signal_off = 1'b1;
            end
          end
        end
        crc_nxt   = CRC_INIT;
        flen_nxt  = 8'd0;
        phase_nxt = PH_SYNC1;
      end
      default: begin
        phase_nxt = PH_SYNC1;
      end
    endcase

    if (frame_err && armed_r) begin
      flags.error_pulse = 1'b1;
      flags.signal_on   = 1'b1;
      upage_nxt         = 8'd0;
    end

    if (!step) begin
      flags     = '{status: ST_NONE, error_pulse: 1'b0, signal_on: 1'b0, signal_off: 1'b0};
      mem_wr.we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      crc_r    <= CRC_INIT;
      ftype_r  <= 8'd0;
      flen_r   <= 8'd0;
      dcnt_r   <= 8'd0;
      crc_hi_r <= 8'd0;
      armed_r  <= 1'b0;
      upage_r  <= 8'd0;
      plen_r   <= '0;
      byte0_r  <= 8'd0;
      byte1_r  <= 8'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      ftype_r  <= ftype_nxt;
      flen_r   <= flen_nxt;
      dcnt_r   <= dcnt_nxt;
      crc_hi_r <= crc_hi_nxt;
      armed_r  <= armed_nxt;
      upage_r  <= upage_nxt;
      plen_r   <= plen_nxt;
      byte0_r  <= byte0_nxt;
      byte1_r  <= byte1_nxt;
    end
  end

  assign page_len = plen_r;

endmodule

// ===== hw/rtl/bootloader_frame_receiver.sv =====
// Channel  | Role    | Payload
// in_bus   | sink    | opcode, rx_byte, read_index, expected_page
// out_bus  | source  | status, error_pulse, signal_on, signal_off, read_data
// cfg_bus  | sink    | index, data (always ready)
//
// One beat in per cycle while in_bus.ready is high, one result beat per input beat:
// the parser settles at the input beat, then a stage register (which also waits
// for the page buffer's registered read) and the output register follow.
// Synchronous active-low reset clears the parser and pipeline valids; the page
// buffer holds no reset contents. A stalled output backs up one stage, then
// drops in_bus.ready.
`include "bootloader_frame_receiver_defines.svh"

module bootloader_frame_receiver #(
  parameter int PAGE_SIZE = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  bfr_in_if.sink    in_bus,
  bfr_out_if.source out_bus,
  bfr_cfg_if.sink   cfg_bus
);
  import bfr_pkg::*;

  localparam int AW    = $clog2(PAGE_SIZE);
  localparam int LEN_W = $clog2(PAGE_SIZE + 1);

  cfg_t             cfg_r;
  flags_t           flags;
  mem_wr_t          mem_wr;
  logic [LEN_W-1:0] page_len;
  logic [7:0]       ram_rdata;
  logic [7:0]       rd_addr;

  logic   in_acc, step, rd_req, rd_in_range;
  logic   s1_move;
  logic   s1_valid_r, s1_rd_r, s1_in_range_r;
  flags_t s1_flags_r;
  logic   out_valid_r, out_rd_r;
  flags_t out_flags_r;
  logic [7:0] out_data_r;

  // configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{code_start: 8'd0, code_end: 8'd1, code_pg_num: 8'd2, code_pg_dat: 8'd3,
                 ver_major: 8'hFF, ver_minor: 8'hFF, ver_check: 1'b0};
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_CODE_START:  cfg_r.code_start  <= cfg_bus.data;
        CFG_CODE_END:    cfg_r.code_end    <= cfg_bus.data;
        CFG_CODE_PG_NUM: cfg_r.code_pg_num <= cfg_bus.data;
        CFG_CODE_PG_DAT: cfg_r.code_pg_dat <= cfg_bus.data;
        CFG_VER_MAJOR:   cfg_r.ver_major   <= cfg_bus.data;
        CFG_VER_MINOR:   cfg_r.ver_minor   <= cfg_bus.data;
        CFG_VER_CHECK:   cfg_r.ver_check   <= cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline advance
  assign s1_move      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_move;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign step         = in_acc && !in_bus.opcode;
  assign rd_req       = in_acc && in_bus.opcode;
  assign rd_in_range  = ({2'b00, in_bus.read_index} < 9'(page_len)) &&
                        ({2'b00, in_bus.read_index} < 9'(PAGE_SIZE));
  assign rd_addr      = {1'b0, in_bus.read_index};

  bfr_parser #(.PAGE_SIZE(PAGE_SIZE)) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .rx_byte       (in_bus.rx_byte),
    .expected_page (in_bus.expected_page),
    .cfg           (cfg_r),
    .flags         (flags),
    .mem_wr        (mem_wr),
    .page_len      (page_len)
  );

  bfr_ram #(.WIDTH(8), .DEPTH(PAGE_SIZE)) u_page_buf (
    .clk   (clk),
    .we    (mem_wr.we),
    .waddr (mem_wr.addr[AW-1:0]),
    .wdata (mem_wr.data),
    .re    (rd_req),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flags_r    <= flags;
      s1_rd_r       <= in_bus.opcode;
      s1_in_range_r <= rd_in_range;
    end
    // read data arrives from the buffer while the beat sits in the stage register
    if (s1_move) begin
      out_flags_r <= s1_flags_r;
      out_rd_r    <= s1_rd_r;
      out_data_r  <= s1_rd_r ? (s1_in_range_r ? ram_rdata : PAD_BYTE) : 8'd0;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = out_flags_r.status;
  assign out_bus.error_pulse = out_flags_r.error_pulse;
  assign out_bus.signal_on   = out_flags_r.signal_on;
  assign out_bus.signal_off  = out_flags_r.signal_off;
  assign out_bus.read_data   = out_data_r;

  `BFR_ASSERT(a_read_quiet, out_valid_r && out_rd_r |-> out_flags_r == '0, "read beat flags")
  `BFR_ASSERT(a_ready_off, out_flags_r.status == ST_PAGE_READY |-> out_bus.signal_off, "no release")
  `BFR_ASSERT(a_stall, !in_bus.ready |-> s1_valid_r && out_valid_r && !out_bus.ready, "in stall")
  `BFR_ASSERT_ALWAYS(a_rst_empty, $past(!rst_n) |-> !out_valid_r && !s1_valid_r, "busy after reset")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for bootloader_frame_receiver: framed serial traffic,
// page reads and register settings, each result checked against an in-bench predictor.
// Depends on bfr_pkg and the bfr_in_if, bfr_out_if and bfr_cfg_if interfaces.
module tb_top;
  import bfr_pkg::*;

  localparam int PAGE_SIZE      = 128;
  localparam int CLK_PERIOD     = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_SHOWN      = 10;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef enum logic [3:0] {
    RX_SYNC1, RX_SYNC2, RX_FLAGS, RX_ADDR, RX_TYPE,
    RX_SECLEN, RX_LEN, RX_DATA, RX_CRCHI, RX_CRCLO
  } rx_phase_t;

  typedef struct packed {
    status_t    status;
    logic       error_pulse;
    logic       signal_on;
    logic       signal_off;
    logic [7:0] read_data;
  } beat_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bfr_in_if  in_bus();
  bfr_out_if out_bus();
  bfr_cfg_if cfg_bus();

  bootloader_frame_receiver #(.PAGE_SIZE(PAGE_SIZE)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver state as the block should hold it.
  rx_phase_t  rx_phase      = RX_SYNC1;
  logic [15:0] crc_acc      = CRC_INIT;
  logic [7:0] frm_type      = 8'h00;
  logic [7:0] frm_len       = 8'h00;
  logic [7:0] data_cnt      = 8'h00;
  logic [7:0] crc_hi        = 8'h00;
  logic       armed         = 1'b0;
  logic [7:0] upcoming_page = 8'h00;
  logic [7:0] page_len      = 8'h00;
  logic [7:0] page_mem [PAGE_SIZE];
  cfg_t       regs          = '{code_start: 8'd0, code_end: 8'd1, code_pg_num: 8'd2,
                                code_pg_dat: 8'd3, ver_major: ANY_VER, ver_minor: ANY_VER,
                                ver_check: 1'b0};

  beat_result_t pending_results [$];
  int  items_sent  = 0;
  int  fail_count  = 0;
  int  idle_cycles = 0;
  bit  gapless     = 1'b0;
  bit  mix_reads   = 1'b0;

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    return x;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic beat_result_t flag_error(beat_result_t r);
    if (armed) begin
      r.error_pulse = 1'b1;
      r.signal_on   = 1'b1;
      upcoming_page = 8'h00;
    end
    return r;
  endfunction

  // Advance the predicted receiver by one beat and return the result it owes.
  function automatic beat_result_t advance_receiver(logic op, logic [7:0] b,
                                                    logic [6:0] idx, logic [7:0] host_page);
    beat_result_t r;
    logic [15:0]  got;
    r = '0;
    r.status = ST_NONE;
    if (op == OP_READ) begin
      r.read_data = (idx < page_len) ? page_mem[idx] : PAD_BYTE;
      return r;
    end
    case (rx_phase)
      RX_SYNC1: begin
        if (b == SYNC_BYTE) rx_phase = RX_SYNC2;
        else r = flag_error(r);
      end
      RX_SYNC2: begin
        if (b == SYNC_BYTE) begin
          crc_acc  = CRC_INIT;
          frm_len  = 8'h00;
          data_cnt = 8'h00;
          rx_phase = RX_FLAGS;
        end else begin
          r = flag_error(r);
          rx_phase = RX_SYNC1;
        end
      end
      RX_FLAGS: begin
        crc_acc  = crc16_byte(crc_acc, b);
        rx_phase = RX_ADDR;
      end
      RX_ADDR: begin
        crc_acc  = crc16_byte(crc_acc, b);
        rx_phase = RX_TYPE;
      end
      RX_TYPE: begin
        crc_acc  = crc16_byte(crc_acc, b);
        frm_type = b;
        rx_phase = RX_SECLEN;
      end
      RX_SECLEN: begin
        crc_acc  = crc16_byte(crc_acc, b);
        rx_phase = RX_LEN;
      end
      RX_LEN: begin
        crc_acc  = crc16_byte(crc_acc, b);
        frm_len  = b;
        data_cnt = 8'h00;
        rx_phase = (b == 8'h00) ? RX_CRCHI : RX_DATA;
      end
      RX_DATA: begin
        crc_acc = crc16_byte(crc_acc, b);
        // count excess bytes but keep them out of the buffer
        if (data_cnt < PAGE_SIZE) page_mem[data_cnt] = b;
        data_cnt = data_cnt + 8'd1;
        if (data_cnt >= frm_len) rx_phase = RX_CRCHI;
      end
      RX_CRCHI: begin
        crc_hi   = b;
        rx_phase = RX_CRCLO;
      end
      RX_CRCLO: begin
        got = {crc_hi, b};
        if (got != crc_acc) begin
          r = flag_error(r);
        end else if (frm_type == regs.code_start) begin
          r.signal_off = 1'b1;
          if (!regs.ver_check ||
              ((regs.ver_major == ANY_VER || page_mem[0] == regs.ver_major) &&
               (regs.ver_minor == ANY_VER || page_mem[1] == regs.ver_minor)))
            armed = 1'b1;
        end else if (frm_type == regs.code_end) begin
          armed    = 1'b0;
          r.status = ST_DONE;
        end else if (armed) begin
          if (frm_type == regs.code_pg_num) begin
            upcoming_page = page_mem[0];
          end else if (frm_type == regs.code_pg_dat) begin
            if (frm_len > PAGE_SIZE || upcoming_page != host_page) begin
              r = flag_error(r);
            end else begin
              for (int i = int'(frm_len); i < PAGE_SIZE; i++) page_mem[i] = PAD_BYTE;
              page_len     = frm_len;
              r.status     = ST_PAGE_READY;
              r.signal_off = 1'b1;
            end
          end
        end
        crc_acc  = CRC_INIT;
        frm_len  = 8'h00;
        rx_phase = RX_SYNC1;
      end
      default: rx_phase = RX_SYNC1;
    endcase
    return r;
  endfunction

  // Mostly short, sometimes long idle stretches.
  function automatic int random_stretch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_item(logic op, logic [7:0] b, logic [6:0] idx, logic [7:0] host_page);
    int gap;
    in_bus.valid         <= 1'b1;
    in_bus.opcode        <= op;
    in_bus.rx_byte       <= b;
    in_bus.read_index    <= idx;
    in_bus.expected_page <= host_page;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(advance_receiver(op, b, idx, host_page));
    items_sent++;
    gap = gapless ? 0 : random_stretch();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_read(logic [6:0] idx);
    send_item(OP_READ, rand_byte(), idx, rand_byte());
  endtask

  task automatic send_rx(logic [7:0] b, logic [7:0] host_page);
    if (mix_reads && $urandom_range(0, 15) == 0) send_read(7'($urandom_range(0, 127)));
    send_item(OP_RECEIVE, b, 7'($urandom_range(0, 127)), host_page);
  endtask

  // Send sync, header, payload and CRC; host_page rides on the last beat.
  task automatic send_frame(logic [7:0] ftype, int len, logic [7:0] d0, logic [7:0] d1,
                            logic [7:0] host_page, bit bad_crc);
    logic [7:0]  hdr [5];
    logic [7:0]  b;
    logic [15:0] c;
    hdr[0] = rand_byte();
    hdr[1] = rand_byte();
    hdr[2] = ftype;
    hdr[3] = rand_byte();
    hdr[4] = 8'(len);
    send_rx(SYNC_BYTE, rand_byte());
    send_rx(SYNC_BYTE, rand_byte());
    c = CRC_INIT;
    for (int i = 0; i < 5; i++) begin
      c = crc16_byte(c, hdr[i]);
      send_rx(hdr[i], rand_byte());
    end
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? d0 : (i == 1) ? d1 : rand_byte();
      c = crc16_byte(c, b);
      send_rx(b, rand_byte());
    end
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
    send_rx(c[15:8], rand_byte());
    send_rx(c[7:0], host_page);
  endtask

  // Feed zero bytes until the parser is back at the first sync byte.
  task automatic flush_parser();
    while (rx_phase != RX_SYNC1) send_rx(8'h00, rand_byte());
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic cfg_beat(cfg_idx_t idx, logic [7:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic apply_settings(cfg_t s);
    drain_results();
    cfg_beat(CFG_CODE_START,  s.code_start);
    cfg_beat(CFG_CODE_END,    s.code_end);
    cfg_beat(CFG_CODE_PG_NUM, s.code_pg_num);
    cfg_beat(CFG_CODE_PG_DAT, s.code_pg_dat);
    cfg_beat(CFG_VER_MAJOR,   s.ver_major);
    cfg_beat(CFG_VER_MINOR,   s.ver_minor);
    cfg_beat(CFG_VER_CHECK,   {7'd0, s.ver_check});
    cfg_bus.valid <= 1'b0;
    regs = s;
  endtask

  task automatic check_result();
    beat_result_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN)
        $display("%0t: result beat with nothing outstanding: ", $realtime,
                 "status=%0d err=%b on=%b off=%b data=%02h",
                 out_bus.status, out_bus.error_pulse, out_bus.signal_on,
                 out_bus.signal_off, out_bus.read_data);
      return;
    end
    want = pending_results.pop_front();
    if (out_bus.status !== want.status || out_bus.error_pulse !== want.error_pulse ||
        out_bus.signal_on !== want.signal_on || out_bus.signal_off !== want.signal_off ||
        out_bus.read_data !== want.read_data) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN)
        $display("%0t: mismatch: want status=%0d err=%b on=%b off=%b data=%02h, ", $realtime,
                 want.status, want.error_pulse, want.signal_on, want.signal_off,
                 want.read_data,
                 "got status=%0d err=%b on=%b off=%b data=%02h",
                 out_bus.status, out_bus.error_pulse, out_bus.signal_on,
                 out_bus.signal_off, out_bus.read_data);
    end
  endtask

  // Result side: random ready stretches, check every accepted beat.
  initial begin
    int  run;
    bit  level;
    run   = 0;
    level = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) check_result();
      if (run == 0) begin
        level = ($urandom_range(0, 99) < 65);
        run   = random_stretch() + 1;
        if (level && $urandom_range(0, 19) == 0) run = $urandom_range(50, 150);
      end
      out_bus.ready <= level;
      run--;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic test_idle_reads();
    send_read(7'd0);
    send_read(7'd127);
    send_rx(8'h00, 8'h00);      // bad first sync, unarmed: silent
    send_rx(SYNC_BYTE, 8'hFF);
    send_rx(8'h7E, 8'h00);      // bad second sync
  endtask

  task automatic test_arm_and_page();
    // start with two payload bytes also fills buffer slots the version check reads
    send_frame(regs.code_start, 2, 8'h5A, 8'hC3, 8'h00, 1'b0);
    send_frame(regs.code_pg_num, 1, 8'h05, 8'h00, 8'h00, 1'b0);
    send_frame(regs.code_pg_dat, 2, 8'h00, 8'hFF, 8'h05, 1'b0);
    send_read(7'd0);
    send_read(7'd1);
    send_read(7'd2);
  endtask

  task automatic test_frame_errors();
    send_frame(regs.code_pg_dat, 0, 8'h00, 8'h00, 8'hFF, 1'b0);  // page mismatch
    send_frame(regs.code_end, 0, 8'h00, 8'h00, 8'h00, 1'b1);     // CRC mismatch
    send_rx(8'h00, 8'hFF);                                       // bad sync, armed
    send_frame(regs.code_end, 0, 8'h00, 8'h00, 8'h00, 1'b0);
    send_rx(8'h00, 8'h00);
  endtask

  function automatic logic [6:0] pick_read_index();
    if (page_len != 0 && $urandom_range(0, 1) == 0)
      return 7'($urandom_range(0, page_len - 1));
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic play_traffic(int until_count);
    int         r, sel, len, n;
    logic [7:0] d0, d1, host;
    bit         bad;
    while (items_sent < until_count) begin
      r       = $urandom_range(0, 99);
      gapless = ($urandom_range(0, 4) == 0);
      if (r < 62) begin
        sel  = $urandom_range(0, 9);
        d0   = rand_byte();
        d1   = rand_byte();
        host = rand_byte();
        bad  = ($urandom_range(0, 99) < 8);
        if (sel < 2) begin
          len = $urandom_range(0, 4);
          if ($urandom_range(0, 9) < 7) d0 = regs.ver_major;
          if ($urandom_range(0, 9) < 7) d1 = regs.ver_minor;
          send_frame(regs.code_start, len, d0, d1, host, bad);
        end else if (sel < 3) begin
          send_frame(regs.code_end, $urandom_range(0, 3), d0, d1, host, bad);
        end else if (sel < 5) begin
          if ($urandom_range(0, 1) == 0) d0 = 8'($urandom_range(0, 3));
          send_frame(regs.code_pg_num, $urandom_range(0, 3), d0, d1, host, bad);
        end else if (sel < 9) begin
          n = $urandom_range(0, 99);
          if (n < 80) len = $urandom_range(0, 12);
          else if (n < 95) len = ($urandom_range(0, 3) == 0) ? PAGE_SIZE
                                                              : $urandom_range(13, PAGE_SIZE);
          else len = $urandom_range(PAGE_SIZE + 1, 255);
          if ($urandom_range(0, 9) < 8) host = upcoming_page;
          send_frame(regs.code_pg_dat, len, d0, d1, host, bad);
        end else begin
          send_frame(rand_byte(), $urandom_range(0, 4), d0, d1, host, bad);
        end
      end else if (r < 72) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_read(pick_read_index());
      end else if (r < 84) begin
        if ($urandom_range(0, 1) == 0) send_rx(SYNC_BYTE, rand_byte());
        send_rx(8'($urandom_range(0, 254)), rand_byte());
      end else if (r < 90) begin
        // truncated frame, then resync
        send_rx(SYNC_BYTE, rand_byte());
        send_rx(SYNC_BYTE, rand_byte());
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) send_rx(rand_byte(), rand_byte());
        flush_parser();
      end else if (r < 97) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_rx(rand_byte(), rand_byte());
        flush_parser();
      end else begin
        // hold the sender until every result is back
        drain_results();
      end
    end
    gapless = 1'b0;
  endtask

  task automatic test_random_traffic();
    cfg_t s;
    mix_reads = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: s = '{code_start: 8'd0, code_end: 8'd1, code_pg_num: 8'd2, code_pg_dat: 8'd3,
                 ver_major: ANY_VER, ver_minor: ANY_VER, ver_check: 1'b0};
        1: s = '{code_start: 8'hFF, code_end: 8'h00, code_pg_num: 8'h80, code_pg_dat: 8'h7F,
                 ver_major: 8'h00, ver_minor: ANY_VER, ver_check: 1'b1};
        2: begin
          // small pool of codes so that overlaps show up
          s.code_start  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                      : rand_byte();
          s.code_end    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                      : rand_byte();
          s.code_pg_num = 8'($urandom_range(0, 3));
          s.code_pg_dat = 8'($urandom_range(0, 3));
          s.ver_major   = ($urandom_range(0, 1) == 0) ? ANY_VER : rand_byte();
          s.ver_minor   = ($urandom_range(0, 1) == 0) ? ANY_VER : rand_byte();
          s.ver_check   = 1'($urandom_range(0, 1));
        end
        default: s = '{code_start: 8'd3, code_end: 8'd2, code_pg_num: 8'd1, code_pg_dat: 8'd0,
                       ver_major: 8'hA5, ver_minor: 8'h00, ver_check: 1'b1};
      endcase
      apply_settings(s);
      play_traffic(items_sent + 200);
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.opcode        <= OP_RECEIVE;
    in_bus.rx_byte       <= 8'h00;
    in_bus.read_index    <= 7'd0;
    in_bus.expected_page <= 8'h00;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= CFG_CODE_START;
    cfg_bus.data         <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_reads();
    test_arm_and_page();
    test_frame_errors();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
